@@ rtl/pkat_pkg.sv @@
// ----------------------------------------------------------------------------
// pkat_pkg
// Types and constants shared by the paged key/value address translator.
// ----------------------------------------------------------------------------
`default_nettype none

package pkat_pkg;

   localparam int POSITION_W   = 12;
   localparam int LENGTH_W     = 13;
   localparam int OPERAND_W    = 13;
   localparam int ADDR_FIELD_W = 30;
   localparam int BLOCK_W      = 7;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 13;
   localparam int DIV_STEPS    = POSITION_W;
   localparam int CNT_W        = $clog2(DIV_STEPS);

   localparam logic [LENGTH_W-1:0] NONE_WRITTEN = 13'h1FFF;

   typedef enum logic [1:0] {
      REQ_MAP   = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_READ  = 2'd2,
      REQ_CLEAR = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_RANGE    = 3'd1,
      ST_UNMAPPED = 3'd2,
      ST_PHYS     = 3'd3,
      ST_EMPTY    = 3'd4
   } status_code_type;

   typedef enum logic [2:0] {
      MUL_LAYER  = 3'd0,
      MUL_HEAD   = 3'd1,
      MUL_OFFSET = 3'd2,
      MUL_POS    = 3'd3,
      MUL_WIDTH  = 3'd4
   } mul_sel_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAGED_MODE  = 3'd0,
      CSR_BLOCK_SIZE  = 3'd1,
      CSR_PHYS_BLOCKS = 3'd2,
      CSR_LAYER_COUNT = 3'd3,
      CSR_HEAD_COUNT  = 3'd4,
      CSR_HEAD_WIDTH  = 3'd5,
      CSR_MAX_POS     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [5:0]            layer;
      logic [3:0]            head;
      logic [POSITION_W-1:0] position;
      logic [5:0]            table_index;
      logic [5:0]            table_block;
      logic                  table_valid;
   } req_item_type;

   typedef struct packed {
      logic [2:0]              status;
      logic [ADDR_FIELD_W-1:0] address;
      logic [LENGTH_W-1:0]     valid_length;
   } rsp_item_type;

   typedef struct packed {
      logic                paged_mode;
      logic [6:0]          block_size;
      logic [6:0]          physical_block_count;
      logic [6:0]          layer_count;
      logic [4:0]          head_count;
      logic [8:0]          head_width;
      logic [LENGTH_W-1:0] max_positions;
   } cfg_type;

   typedef struct packed {
      logic         valid;
      logic [BLOCK_W-1:0] block;
   } map_entry_type;

   typedef struct packed {
      logic            load;
      logic            map_write;
      logic            set_status;
      status_code_type status_code;
      logic            div_start;
      logic            div_step;
      logic            map_read;
      logic            acc_init;
      logic            mul_step;
      mul_sel_type     mul_sel;
      logic            sweep;
      logic            finish;
   } dp_cmd_type;

   typedef struct packed {
      req_kind_type req_kind;
      logic         paged;
      logic         tidx_ok;
      logic         range_bad_w;
      logic         lh_bad;
      logic         len_zero;
      logic         pos_ge_len;
      logic         lblock_out;
      logic         unmapped;
      logic         phys_bad;
      logic         sweep_last;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/paged_kv_address_translator.sv @@
// ----------------------------------------------------------------------------
// paged_kv_address_translator
// Translates key/value cache token accesses to element addresses through a
// block map (paged layout) or a fixed layout (contiguous).
//
// A transaction is accepted when start is high and busy is low; req_item
// carries the request. Exactly one response follows: rsp_valid is high for a
// single cycle with rsp_item, and the receiver cannot hold it off.
// Configuration goes through the csr channel (always ready); the user must
// write it only while idle, as the block itself does not enforce this.
// Map writes, clears and requests rejected at decode respond directly;
// paged accesses run the bit-serial divider for position / block size,
// one block map read, then four steps through the single multiply-add unit.
// One transaction is in flight at a time; busy covers it.
// After reset the block map is swept to its identity mapping, one entry per
// cycle with busy high; csr writes still go in.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_kv_address_translator
   import pkat_pkg::*;
#(
   parameter int MAX_LOGICAL_BLOCKS = 64,
   parameter int ADDRESS_BITS       = 30
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  req_item_type                req_item,
   output logic                        rsp_valid,
   output rsp_item_type                rsp_item,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type sts;

   pkat_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pkat_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   pkat_dp #(
      .MAX_LOGICAL_BLOCKS (MAX_LOGICAL_BLOCKS),
      .ADDRESS_BITS       (ADDRESS_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_item  (req_item),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

@@ rtl/pkat_regs.sv @@
// ----------------------------------------------------------------------------
// pkat_regs
// Configuration register file, written through the csr channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pkat_regs
   import pkat_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PAGED_MODE:  cfg_in.paged_mode           = csr_data[0];
            CSR_BLOCK_SIZE:  cfg_in.block_size           = csr_data[6:0];
            CSR_PHYS_BLOCKS: cfg_in.physical_block_count = csr_data[6:0];
            CSR_LAYER_COUNT: cfg_in.layer_count          = csr_data[6:0];
            CSR_HEAD_COUNT:  cfg_in.head_count           = csr_data[4:0];
            CSR_HEAD_WIDTH:  cfg_in.head_width           = csr_data[8:0];
            CSR_MAX_POS:     cfg_in.max_positions        = csr_data[LENGTH_W-1:0];
            default:         cfg_in                      = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.paged_mode           <= 1'b0;
         cfg_ff.block_size           <= 7'd16;
         cfg_ff.physical_block_count <= 7'd64;
         cfg_ff.layer_count          <= 7'd32;
         cfg_ff.head_count           <= 5'd8;
         cfg_ff.head_width           <= 9'd128;
         cfg_ff.max_positions        <= 13'd1024;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/pkat_dp.sv @@
// ----------------------------------------------------------------------------
// pkat_dp
// Datapath: request capture, block map memory, restoring divider,
// shared multiply-add unit, written-length tracking and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module pkat_dp
   import pkat_pkg::*;
#(
   parameter int MAX_LOGICAL_BLOCKS = 64,
   parameter int ADDRESS_BITS       = 30
)
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  cfg_type     cfg,
   input  req_item_type req_item,
   input  dp_cmd_type  cmd,
   output dp_status_type sts,
   output logic        rsp_valid,
   output rsp_item_type rsp_item
);

   localparam int IDX_W  = (MAX_LOGICAL_BLOCKS > 1) ? $clog2(MAX_LOGICAL_BLOCKS) : 1;
   localparam int PROD_W = ADDRESS_BITS + OPERAND_W;

   function automatic logic [LENGTH_W-1:0] valid_len(input logic [LENGTH_W-1:0] hw,
                                                     input logic [LENGTH_W-1:0] lim);
      logic [LENGTH_W-1:0] inc;
      begin
         inc = hw + 13'd1;
         if (hw == NONE_WRITTEN) begin
            valid_len = '0;
         end else if (inc > lim) begin
            valid_len = lim;
         end else begin
            valid_len = inc;
         end
      end
   endfunction

   map_entry_type map_mem [MAX_LOGICAL_BLOCKS];

   req_item_type          req_ff;
   status_code_type       status_ff;
   logic [BLOCK_W-1:0]    rem_ff;
   logic [POSITION_W-1:0] quo_ff;
   map_entry_type         rd_ff;
   logic [ADDRESS_BITS-1:0] acc_ff;
   logic [ADDRESS_BITS-1:0] acc_in;
   logic [LENGTH_W-1:0]   hw_ff;
   logic [LENGTH_W-1:0]   hw_in;
   logic [IDX_W-1:0]      sweep_ff;
   logic                  rsp_valid_ff;
   rsp_item_type          rsp_ff;
   rsp_item_type          rsp_in;

   logic [6:0]            bs_eff;
   logic [7:0]            trial;
   logic [LENGTH_W-1:0]   cur_len;
   logic                  lh_bad;
   logic [15:0]           tidx_ext;
   logic [15:0]           quo_ext;
   logic [15:0]           sweep_ext;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_wa;
   map_entry_type         mem_wd;
   logic [OPERAND_W-1:0]  mul_op;
   logic [ADDRESS_BITS-1:0] mul_add;
   logic [PROD_W-1:0]     prod;
   logic [63:0]           acc_wide;
   logic                  write_ok;

   assign bs_eff    = (cfg.block_size == 7'd0) ? 7'd1 : cfg.block_size;
   assign trial     = {rem_ff, quo_ff[POSITION_W-1]};
   assign cur_len   = valid_len(hw_ff, cfg.max_positions);
   assign lh_bad    = ({1'b0, req_ff.layer} >= cfg.layer_count) ||
                      ({1'b0, req_ff.head} >= cfg.head_count);
   assign tidx_ext  = 16'(req_ff.table_index);
   assign quo_ext   = 16'(quo_ff);
   assign sweep_ext = 16'(sweep_ff);

   assign sts.req_kind    = req_kind_type'(req_ff.req_type);
   assign sts.paged       = cfg.paged_mode;
   assign sts.tidx_ok     = tidx_ext < 16'(MAX_LOGICAL_BLOCKS);
   assign sts.range_bad_w = ({1'b0, req_ff.position} >= cfg.max_positions) || lh_bad;
   assign sts.lh_bad      = lh_bad;
   assign sts.len_zero    = (cur_len == '0);
   assign sts.pos_ge_len  = ({1'b0, req_ff.position} >= cur_len);
   assign sts.lblock_out  = quo_ext >= 16'(MAX_LOGICAL_BLOCKS);
   assign sts.unmapped    = !rd_ff.valid;
   assign sts.phys_bad    = rd_ff.block >= cfg.physical_block_count;
   assign sts.sweep_last  = (sweep_ff == IDX_W'(MAX_LOGICAL_BLOCKS - 1));

   // block map write port: identity sweep after reset, or a table request
   always_comb begin
      mem_we = cmd.sweep || (cmd.map_write && sts.tidx_ok);
      if (cmd.sweep) begin
         mem_wa       = sweep_ff;
         mem_wd.valid = 1'b1;
         mem_wd.block = (sweep_ext < 16'd128) ? sweep_ext[BLOCK_W-1:0] : 7'd127;
      end else begin
         mem_wa       = tidx_ext[IDX_W-1:0];
         mem_wd.valid = req_ff.table_valid;
         mem_wd.block = {1'b0, req_ff.table_block};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_wa] <= mem_wd;
      end
      if (cmd.map_read) begin
         rd_ff <= map_mem[quo_ext[IDX_W-1:0]];
      end
   end

   // shared multiply-add: acc = acc * operand + addend, modulo 2^ADDRESS_BITS
   always_comb begin
      case (cmd.mul_sel)
         MUL_LAYER: begin
            mul_op  = 13'(cfg.layer_count);
            mul_add = ADDRESS_BITS'(req_ff.layer);
         end
         MUL_HEAD: begin
            mul_op  = 13'(cfg.head_count);
            mul_add = ADDRESS_BITS'(req_ff.head);
         end
         MUL_OFFSET: begin
            mul_op  = 13'(bs_eff);
            mul_add = ADDRESS_BITS'(rem_ff);
         end
         MUL_POS: begin
            mul_op  = cfg.max_positions;
            mul_add = ADDRESS_BITS'(req_ff.position);
         end
         default: begin
            mul_op  = 13'(cfg.head_width);
            mul_add = '0;
         end
      endcase
      prod = PROD_W'(acc_ff) * PROD_W'(mul_op) + PROD_W'(mul_add);
      if (cmd.acc_init) begin
         acc_in = cfg.paged_mode ? ADDRESS_BITS'(rd_ff.block) : ADDRESS_BITS'(req_ff.layer);
      end else if (cmd.mul_step) begin
         acc_in = prod[ADDRESS_BITS-1:0];
      end else begin
         acc_in = acc_ff;
      end
   end

   assign acc_wide = 64'(acc_ff);

   always_comb begin
      write_ok = (sts.req_kind == REQ_WRITE) && (status_ff == ST_OK);
      hw_in    = hw_ff;
      if (cmd.finish) begin
         if (sts.req_kind == REQ_CLEAR) begin
            hw_in = NONE_WRITTEN;
         end else if (write_ok &&
                      (hw_ff == NONE_WRITTEN || {1'b0, req_ff.position} > hw_ff)) begin
            hw_in = {1'b0, req_ff.position};
         end
      end
      rsp_in.status       = status_ff;
      rsp_in.address      = ((status_ff == ST_OK) &&
                             (sts.req_kind == REQ_WRITE || sts.req_kind == REQ_READ)) ?
                            acc_wide[ADDR_FIELD_W-1:0] : '0;
      rsp_in.valid_length = valid_len(hw_in, cfg.max_positions);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= req_ff.position;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[POSITION_W-2:0], (trial >= {1'b0, bs_eff})};
         rem_ff <= (trial >= {1'b0, bs_eff}) ? 7'(trial - {1'b0, bs_eff}) : trial[6:0];
      end
      acc_ff <= acc_in;
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff        <= NONE_WRITTEN;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hw_ff        <= hw_in;
         rsp_valid_ff <= cmd.finish;
         if (cmd.sweep) begin
            sweep_ff <= sweep_ff + 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/pkat_ctrl.sv @@
// ----------------------------------------------------------------------------
// pkat_ctrl
// Controller: sequences map sweep, checks, division, lookup and the
// multiply-add chain for each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module pkat_ctrl
   import pkat_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  dp_status_type sts,
   output dp_cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_DECODE,
      S_DIV,
      S_LBLK,
      S_LOOK,
      S_MUL,
      S_FINISH
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             mul_last;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      mul_last = sts.paged ? (cnt_ff == CNT_W'(3)) : (cnt_ff == CNT_W'(2));
      unique case (state_ff)
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_OK;
            cnt_in          = '0;
            state_in        = S_FINISH;
            unique case (sts.req_kind)
               REQ_MAP: begin
                  cmd.map_write = 1'b1;
                  if (!sts.tidx_ok) begin
                     cmd.status_code = ST_RANGE;
                  end
               end
               REQ_WRITE: begin
                  if (sts.range_bad_w) begin
                     cmd.status_code = ST_RANGE;
                  end else if (sts.paged) begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIV;
                  end else begin
                     cmd.acc_init = 1'b1;
                     state_in     = S_MUL;
                  end
               end
               REQ_READ: begin
                  if (sts.len_zero) begin
                     cmd.status_code = ST_EMPTY;
                  end else if (sts.pos_ge_len) begin
                     cmd.status_code = ST_RANGE;
                  end else if (sts.paged) begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIV;
                  end else if (sts.lh_bad) begin
                     cmd.status_code = ST_RANGE;
                  end else begin
                     cmd.acc_init = 1'b1;
                     state_in     = S_MUL;
                  end
               end
               default: begin
                  cmd.status_code = ST_OK;
               end
            endcase
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_LBLK;
            end
         end
         S_LBLK: begin
            if (sts.lblock_out) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_UNMAPPED;
               state_in        = S_FINISH;
            end else begin
               cmd.map_read = 1'b1;
               state_in     = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_FINISH;
            if (sts.unmapped) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_UNMAPPED;
            end else if (sts.phys_bad) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_PHYS;
            end else if (sts.req_kind == REQ_READ && sts.lh_bad) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_RANGE;
            end else begin
               cmd.acc_init = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (sts.paged) begin
               unique case (cnt_ff)
                  CNT_W'(0): cmd.mul_sel = MUL_LAYER;
                  CNT_W'(1): cmd.mul_sel = MUL_HEAD;
                  CNT_W'(2): cmd.mul_sel = MUL_OFFSET;
                  default:   cmd.mul_sel = MUL_WIDTH;
               endcase
            end else begin
               unique case (cnt_ff)
                  CNT_W'(0): cmd.mul_sel = MUL_HEAD;
                  CNT_W'(1): cmd.mul_sel = MUL_POS;
                  default:   cmd.mul_sel = MUL_WIDTH;
               endcase
            end
            if (mul_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire
